// File: rtl/gsm_pkg.sv
// Shared types and constants of the gear-shift mode controller.
`timescale 1ns / 1ps

package gsm_pkg;

  // Action codes on the input channel
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_TOGGLE = 3'd1;
  localparam logic [2:0] ACT_UP     = 3'd2;
  localparam logic [2:0] ACT_DOWN   = 3'd3;
  localparam logic [2:0] ACT_WRITE  = 3'd4;

  // Largest servo angle in degrees
  localparam logic [7:0] SERVO_MAX = 8'd180;

  // Operation decoded by the front end
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_TOGGLE,
    OP_UP,
    OP_DOWN,
    OP_WRITE
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LIMIT = 2'd1,
    ST_HOLD  = 2'd2,
    ST_UNCAL = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_GEAR_COUNT     = 3'd0,
    CFG_ANGLE_FLOOR    = 3'd1,
    CFG_ANGLE_CEILING  = 3'd2,
    CFG_OVERSHOOT_UP   = 3'd3,
    CFG_OVERSHOOT_DOWN = 3'd4,
    CFG_MANUAL_STEP    = 3'd5,
    CFG_HOLD_TICKS     = 3'd6
  } cfg_reg_t;

  // Classified command passed from front end to back end
  typedef struct packed {
    op_t        op;
    logic [3:0] tbl_index;
    logic [7:0] tbl_angle;
    logic       battery;
  } cmd_t;

endpackage

// File: rtl/gsm_front.sv
// Front end: accepts input transactions and classifies them into commands.
`timescale 1ns / 1ps

module gsm_front #(
  parameter int GEAR_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  logic [2:0]    action,
  input  logic [3:0]    table_index,
  input  logic [7:0]    table_angle,
  input  logic          battery_low,
  output logic          push,
  output gsm_pkg::cmd_t push_cmd,
  input  logic          q_full
);

  logic          f_valid;
  gsm_pkg::cmd_t f_cmd;
  gsm_pkg::cmd_t dec_cmd;
  logic          accept;

  // Stall only when the staged command cannot move into the queue
  assign item_stall = f_valid && q_full;
  assign accept     = item_valid && !item_stall;
  assign push       = f_valid && !q_full;
  assign push_cmd   = f_cmd;

  // Decode action, drop out-of-range table writes, saturate the table angle
  always_comb begin
    dec_cmd.tbl_index = table_index;
    dec_cmd.battery   = battery_low;
    dec_cmd.tbl_angle = (table_angle > gsm_pkg::SERVO_MAX) ? gsm_pkg::SERVO_MAX : table_angle;
    unique case (action)
      gsm_pkg::ACT_TICK:   dec_cmd.op = gsm_pkg::OP_TICK;
      gsm_pkg::ACT_TOGGLE: dec_cmd.op = gsm_pkg::OP_TOGGLE;
      gsm_pkg::ACT_UP:     dec_cmd.op = gsm_pkg::OP_UP;
      gsm_pkg::ACT_DOWN:   dec_cmd.op = gsm_pkg::OP_DOWN;
      gsm_pkg::ACT_WRITE:  begin
        dec_cmd.op = (int'(table_index) < GEAR_SLOTS) ? gsm_pkg::OP_WRITE : gsm_pkg::OP_NONE;
      end
      default:             dec_cmd.op = gsm_pkg::OP_NONE;
    endcase
  end

  // Stage valid: set on accept, clear once pushed
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd <= dec_cmd;
    end
  end

endmodule

// File: rtl/gsm_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module gsm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gsm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output gsm_pkg::cmd_t head_cmd
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  gsm_pkg::cmd_t   q_mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == (PW+1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = q_mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/gsm_back.sv
// Back end: configuration, controller state, gear table and result register.
`timescale 1ns / 1ps

module gsm_back #(
  parameter int GEAR_SLOTS    = 16,
  parameter int LED_ON_TICKS  = 500,
  parameter int LED_OFF_TICKS = 500,
  parameter int GLOW_TICKS    = 3000,
  parameter int CENTER_ANGLE  = 90
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [11:0]   cfg_data,
  input  logic          head_valid,
  input  gsm_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [7:0]    servo_angle,
  output logic [3:0]    gear,
  output logic          manual_mode,
  output logic          mode_lamp,
  output logic          battery_lamp,
  output logic [1:0]    status
);

  localparam int TD     = (GEAR_SLOTS < 16) ? GEAR_SLOTS : 16;
  localparam int TIW    = $clog2(TD);
  localparam int PERIOD = LED_ON_TICKS + LED_OFF_TICKS;
  localparam int BW     = $clog2(PERIOD);
  localparam int GW     = $clog2(GLOW_TICKS + 1);

  // Configuration registers
  logic [4:0]  gear_count;
  logic [7:0]  angle_floor;
  logic [7:0]  angle_ceiling;
  logic [4:0]  overshoot_up;
  logic [4:0]  overshoot_down;
  logic [4:0]  manual_step;
  logic [11:0] hold_ticks;

  // Controller state
  logic          mode_manual,  mode_manual_next;
  logic [4:0]    gear_index,   gear_index_next;
  logic [7:0]    angle_now,    angle_now_next;
  logic [7:0]    settle_angle, settle_angle_next;
  logic [11:0]   hold_left,    hold_left_next;
  logic [BW-1:0] blink_phase,  blink_phase_next;
  logic [GW-1:0] glow_left,    glow_left_next;
  logic [7:0]    gear_angles [TD];

  gsm_pkg::status_t st_next;
  logic             blink_on_next;

  // Step by one result when the output register is free or being taken
  assign pop = head_valid && (!result_valid || !result_stall);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gear_count     <= 5'd0;
      angle_floor    <= 8'd0;
      angle_ceiling  <= 8'd180;
      overshoot_up   <= 5'd5;
      overshoot_down <= 5'd5;
      manual_step    <= 5'd2;
      hold_ticks     <= 12'd500;
    end else if (cfg_valid) begin
      unique case (gsm_pkg::cfg_reg_t'(cfg_index))
        gsm_pkg::CFG_GEAR_COUNT:     gear_count     <= cfg_data[4:0];
        gsm_pkg::CFG_ANGLE_FLOOR:    angle_floor    <= cfg_data[7:0];
        gsm_pkg::CFG_ANGLE_CEILING:  angle_ceiling  <= cfg_data[7:0];
        gsm_pkg::CFG_OVERSHOOT_UP:   overshoot_up   <= cfg_data[4:0];
        gsm_pkg::CFG_OVERSHOOT_DOWN: overshoot_down <= cfg_data[4:0];
        gsm_pkg::CFG_MANUAL_STEP:    manual_step    <= cfg_data[4:0];
        gsm_pkg::CFG_HOLD_TICKS:     hold_ticks     <= cfg_data;
        default:                     ;
      endcase
    end
  end

  // Execute the head command
  always_comb begin
    logic [4:0]        n;
    logic [4:0]        target;
    logic [7:0]        tbl_rd;
    logic [8:0]        over_sum;
    logic [7:0]        shot;
    logic signed [9:0] x;
    logic signed [9:0] lo;
    logic signed [9:0] hi;
    logic signed [9:0] dx;

    mode_manual_next  = mode_manual;
    gear_index_next   = gear_index;
    angle_now_next    = angle_now;
    settle_angle_next = settle_angle;
    hold_left_next    = hold_left;
    blink_phase_next  = blink_phase;
    glow_left_next    = glow_left;
    st_next           = gsm_pkg::ST_OK;

    n = (int'(gear_count) > GEAR_SLOTS) ? 5'(GEAR_SLOTS) : gear_count;
    if (head_cmd.op == gsm_pkg::OP_UP) begin
      target = gear_index + 5'd1;
    end else begin
      target = ((gear_index > n) ? n : gear_index) - 5'd1;
    end
    tbl_rd = gear_angles[target[TIW-1:0]];
    over_sum = {1'b0, tbl_rd} + {4'd0, overshoot_up};

    // Manual step with floor, ceiling and range clamp
    dx = $signed({5'd0, manual_step});
    lo = $signed({2'd0, angle_floor});
    hi = $signed({2'd0, angle_ceiling});
    x  = $signed({2'd0, angle_now}) + ((head_cmd.op == gsm_pkg::OP_UP) ? dx : -dx);
    if (x < lo) begin
      x = lo;
    end else if (x > hi) begin
      x = hi;
    end
    if (x > $signed({2'd0, gsm_pkg::SERVO_MAX})) begin
      x = $signed({2'd0, gsm_pkg::SERVO_MAX});
    end

    if (head_cmd.op == gsm_pkg::OP_UP) begin
      shot = (over_sum > {1'b0, gsm_pkg::SERVO_MAX}) ? gsm_pkg::SERVO_MAX : over_sum[7:0];
    end else begin
      shot = (tbl_rd < {3'd0, overshoot_down}) ? 8'd0 : (tbl_rd - {3'd0, overshoot_down});
    end

    unique case (head_cmd.op)
      gsm_pkg::OP_TICK: begin
        blink_phase_next = (blink_phase == BW'(PERIOD - 1)) ? '0 : blink_phase + 1'b1;
        if (glow_left != '0) begin
          glow_left_next = glow_left - 1'b1;
        end
        if (hold_left != 12'd0) begin
          hold_left_next = hold_left - 12'd1;
          if (hold_left == 12'd1) begin
            angle_now_next = settle_angle;
          end
        end
      end
      gsm_pkg::OP_TOGGLE: begin
        if (hold_left != 12'd0) begin
          st_next = gsm_pkg::ST_HOLD;
        end else begin
          mode_manual_next = !mode_manual;
          glow_left_next   = GW'(GLOW_TICKS);
        end
      end
      gsm_pkg::OP_UP, gsm_pkg::OP_DOWN: begin
        priority if (hold_left != 12'd0) begin
          st_next = gsm_pkg::ST_HOLD;
        end else if (mode_manual) begin
          angle_now_next = x[7:0];
        end else if (n == 5'd0) begin
          st_next = gsm_pkg::ST_UNCAL;
        end else if ((head_cmd.op == gsm_pkg::OP_UP) &&
                     (({1'b0, gear_index} + 6'd1) >= {1'b0, n})) begin
          st_next = gsm_pkg::ST_LIMIT;
        end else if ((head_cmd.op == gsm_pkg::OP_DOWN) && (gear_index == 5'd0)) begin
          st_next = gsm_pkg::ST_LIMIT;
        end else begin
          settle_angle_next = tbl_rd;
          gear_index_next   = target;
          if (hold_ticks == 12'd0) begin
            angle_now_next = tbl_rd;
          end else begin
            angle_now_next = shot;
            hold_left_next = hold_ticks;
          end
        end
      end
      default: ;
    endcase

    blink_on_next = (int'(blink_phase_next) < LED_ON_TICKS);
  end

  // Update controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_manual  <= 1'b0;
      gear_index   <= 5'd0;
      angle_now    <= 8'(CENTER_ANGLE);
      settle_angle <= 8'd0;
      hold_left    <= 12'd0;
      blink_phase  <= '0;
      glow_left    <= '0;
    end else if (pop) begin
      mode_manual  <= mode_manual_next;
      gear_index   <= gear_index_next;
      angle_now    <= angle_now_next;
      settle_angle <= settle_angle_next;
      hold_left    <= hold_left_next;
      blink_phase  <= blink_phase_next;
      glow_left    <= glow_left_next;
    end
  end

  // Write the gear table
  always_ff @(posedge clk) begin
    if (pop && (head_cmd.op == gsm_pkg::OP_WRITE)) begin
      gear_angles[head_cmd.tbl_index[TIW-1:0]] <= head_cmd.tbl_angle;
    end
  end

  // Result valid: set on pop, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      servo_angle  <= angle_now_next;
      gear         <= gear_index_next[3:0];
      manual_mode  <= mode_manual_next;
      mode_lamp    <= (glow_left_next != '0) || (mode_manual_next && blink_on_next);
      battery_lamp <= blink_on_next && head_cmd.battery;
      status       <= st_next;
    end
  end

endmodule

// File: rtl/gear_shift_mode_controller_core.sv
// Top level of the servo gear-shift mode controller.
// Path: an accepted transaction is registered in the front stage, then in the
// four-entry queue, then its result in the result register. Throughput: one
// transaction per cycle unless stalled; the back end executes one command a cycle.
// Reset: synchronous, active high; clears control state, loads register defaults,
// centers the servo. Gear table entries are undefined until written.
`timescale 1ns / 1ps

module gear_shift_mode_controller_core #(
  parameter int GEAR_SLOTS    = 16,
  parameter int LED_ON_TICKS  = 500,
  parameter int LED_OFF_TICKS = 500,
  parameter int GLOW_TICKS    = 3000,
  parameter int CENTER_ANGLE  = 90
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  action,
  input  logic [3:0]  table_index,
  input  logic [7:0]  table_angle,
  input  logic        battery_low,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  servo_angle,
  output logic [3:0]  gear,
  output logic        manual_mode,
  output logic        mode_lamp,
  output logic        battery_lamp,
  output logic [1:0]  status
);

  logic          push;
  gsm_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          pop;
  logic          head_valid;
  gsm_pkg::cmd_t head_cmd;

  // Configuration writes are always accepted and land in the next cycle
  assign cfg_ready = 1'b1;

  gsm_front #(
    .GEAR_SLOTS (GEAR_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .action      (action),
    .table_index (table_index),
    .table_angle (table_angle),
    .battery_low (battery_low),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_full      (q_full)
  );

  gsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  gsm_back #(
    .GEAR_SLOTS    (GEAR_SLOTS),
    .LED_ON_TICKS  (LED_ON_TICKS),
    .LED_OFF_TICKS (LED_OFF_TICKS),
    .GLOW_TICKS    (GLOW_TICKS),
    .CENTER_ANGLE  (CENTER_ANGLE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .servo_angle  (servo_angle),
    .gear         (gear),
    .manual_mode  (manual_mode),
    .mode_lamp    (mode_lamp),
    .battery_lamp (battery_lamp),
    .status       (status)
  );

endmodule

// File: rtl/gsm_checker.sv
// Port-level checker of the gear-shift mode controller, bound to the top level.
`timescale 1ns / 1ps

module gsm_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] servo_angle,
  input logic [1:0] status
);

  // Result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // Configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

  // Servo command stays within range
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (servo_angle <= 8'd180))
    else $error("servo angle out of range");

  // Stalled result stays valid
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  // Stalled result payload holds
  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(servo_angle) && $stable(status))
    else $error("stalled result payload changed");

endmodule

bind gear_shift_mode_controller_core gsm_checker u_gsm_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .servo_angle  (servo_angle),
  .status       (status)
);
